[src/exp_golomb_bitstream_reader_macros.svh]
// ---------------------------------------------------------------------------
// Exp-Golomb bitstream reader assertion macros
// Property forms for the checks in the reader's datapath.
// ---------------------------------------------------------------------------
`ifndef EXP_GOLOMB_BITSTREAM_READER_MACROS_SVH
`define EXP_GOLOMB_BITSTREAM_READER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EGB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define EGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/egb_pkg.sv]
// ---------------------------------------------------------------------------
// Exp-Golomb bitstream reader package
// Constants, operation and status codes, and controller/datapath bundles.
// ---------------------------------------------------------------------------
package egb_pkg;

  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int POS_W     = 16;
  localparam int CNT_W     = 7;
  localparam int LZ_W      = 5;

  localparam logic [POS_W-1:0] MAX_READ_BITS = POS_W'(64);
  localparam logic [POS_W-1:0] FULL_BITS     = POS_W'(BUF_BYTES * 8);
  localparam logic [LZ_W-1:0]  MAX_LZ        = LZ_W'(31);
  localparam logic [7:0]       EMU_BYTE      = 8'h03;

  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_APPEND    = 3'd1;
  localparam logic [2:0] OP_READ_BITS = 3'd2;
  localparam logic [2:0] OP_READ_UE   = 3'd3;
  localparam logic [2:0] OP_READ_SE   = 3'd4;
  localparam logic [2:0] OP_SKIP      = 3'd5;
  localparam logic [2:0] OP_ALIGN     = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic latch;
    logic exec_simple;
    logic init_read;
    logic init_ue;
    logic set_fail;
    logic step;
    logic commit;
  } egb_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       count_bad;
    logic       count_zero;
    logic       at_end;
    logic       bit_val;
    logic       prefix;
    logic       lz_zero;
    logic       lz_max;
    logic       rem_one;
    logic       suffix_short;
    logic       last_data;
    logic       byte_last;
    logic       out_free;
  } egb_stat_t;

endpackage

[src/egb_ctrl.sv]
// ---------------------------------------------------------------------------
// Exp-Golomb bitstream reader controller
// Sequences one item at a time: decode, byte fetch, bit steps, result.
// ---------------------------------------------------------------------------
module egb_ctrl
  import egb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  egb_stat_t stat_i,
  output egb_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_BIT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] fetch_next;

  // A bit step that leaves the current byte has to wait for a new fetch.
  assign fetch_next = stat_i.byte_last ? S_LOAD : S_BIT;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_READ_BITS: begin
            if (stat_i.count_bad) begin
              cmd_o.set_fail = 1'b1;
              state_d        = S_DONE;
            end else begin
              cmd_o.init_read = 1'b1;
              state_d         = stat_i.count_zero ? S_DONE : S_LOAD;
            end
          end
          OP_READ_UE, OP_READ_SE: begin
            if (stat_i.at_end) begin
              cmd_o.set_fail = 1'b1;
              state_d        = S_DONE;
            end else begin
              cmd_o.init_ue = 1'b1;
              state_d       = S_LOAD;
            end
          end
          default: begin
            cmd_o.exec_simple = 1'b1;
            state_d           = S_DONE;
          end
        endcase
      end
      S_LOAD: begin
        state_d = S_BIT;
      end
      S_BIT: begin
        cmd_o.step = 1'b1;
        if (stat_i.prefix) begin
          if (stat_i.bit_val) begin
            if (stat_i.lz_zero) begin
              state_d = S_DONE;
            end else if (stat_i.suffix_short) begin
              cmd_o.set_fail = 1'b1;
              state_d        = S_DONE;
            end else begin
              state_d = fetch_next;
            end
          end else if (stat_i.lz_max || stat_i.rem_one) begin
            cmd_o.set_fail = 1'b1;
            state_d        = S_DONE;
          end else begin
            state_d = fetch_next;
          end
        end else begin
          state_d = stat_i.last_data ? S_DONE : fetch_next;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/egb_datapath.sv]
// ---------------------------------------------------------------------------
// Exp-Golomb bitstream reader datapath
// Byte store, fill and read positions, bit accumulator and result register.
// ---------------------------------------------------------------------------
`include "exp_golomb_bitstream_reader_macros.svh"

module egb_datapath
  import egb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [2:0]        op_i,
  input  logic [15:0]       bit_count_arg_i,
  input  logic [7:0]        byte_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [63:0]       read_value_o,
  output logic signed [31:0] signed_value_o,
  output logic              byte_dropped_o,
  output logic [15:0]       position_out_o,
  output logic [15:0]       remaining_out_o,
  input  egb_cmd_t          cmd_i,
  output egb_stat_t         stat_o
);

  logic [7:0]       mem [BUF_BYTES];
  logic [7:0]       rdata_q;
  logic             mem_we;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] fill_q, fill_d;
  logic [1:0]       zrun_q, zrun_d;
  logic             strip_q;
  logic             out_valid_q, out_valid_d;
  logic             fail_q, fail_d;
  logic [1:0]       status_q, status_d;
  logic             dropped_q, dropped_d;

  logic [2:0]       op_q;
  logic [15:0]      arg_q;
  logic [7:0]       byte_q;
  logic [63:0]      acc_q;
  logic [LZ_W-1:0]  lz_q;
  logic [CNT_W-1:0] cnt_q;
  logic             prefix_q;

  logic [POS_W-1:0] rem;
  logic             bit_val;
  logic [POS_W-1:0] aligned;
  logic [31:0]      half;

  logic [1:0]       res_status_q;
  logic [63:0]      res_rval_q, res_rval_d;
  logic [31:0]      res_sval_q, res_sval_d;
  logic             res_dropped_q;
  logic [POS_W-1:0] res_pos_q;
  logic [POS_W-1:0] res_rem_q;

  assign rem     = fill_q - pos_q;
  assign bit_val = rdata_q[~pos_q[2:0]];
  assign aligned = (pos_q + POS_W'(7)) & ~POS_W'(7);
  assign half    = {1'b0, acc_q[31:1]};

  assign stat_o.op           = op_q;
  assign stat_o.count_bad    = (arg_q > MAX_READ_BITS) || (arg_q > rem);
  assign stat_o.count_zero   = (arg_q == '0);
  assign stat_o.at_end       = (pos_q == fill_q);
  assign stat_o.bit_val      = bit_val;
  assign stat_o.prefix       = prefix_q;
  assign stat_o.lz_zero      = (lz_q == '0);
  assign stat_o.lz_max       = (lz_q == MAX_LZ);
  assign stat_o.rem_one      = (rem == POS_W'(1));
  assign stat_o.suffix_short = ({{(POS_W-LZ_W){1'b0}}, lz_q} >= rem);
  assign stat_o.last_data    = (cnt_q == CNT_W'(1));
  assign stat_o.byte_last    = (pos_q[2:0] == 3'd7);
  assign stat_o.out_free     = !out_valid_q || !out_stall_i;

  // Simple operations, status and fail flags, and the position bookkeeping of bit steps.
  always_comb begin
    pos_d     = pos_q;
    fill_d    = fill_q;
    zrun_d    = zrun_q;
    fail_d    = fail_q;
    status_d  = status_q;
    dropped_d = dropped_q;
    mem_we    = 1'b0;
    if (cmd_i.latch) begin
      fail_d    = 1'b0;
      status_d  = ST_OK;
      dropped_d = 1'b0;
    end
    if (cmd_i.set_fail) begin
      fail_d = 1'b1;
    end
    if (cmd_i.step) begin
      pos_d = pos_q + POS_W'(1);
    end
    if (cmd_i.exec_simple) begin
      case (op_q)
        OP_CLEAR: begin
          pos_d  = '0;
          fill_d = '0;
          zrun_d = '0;
        end
        OP_APPEND: begin
          if (strip_q && (zrun_q == 2'd2) && (byte_q == EMU_BYTE)) begin
            dropped_d = 1'b1;
            zrun_d    = '0;
          end else if (fill_q == FULL_BITS) begin
            status_d = ST_FULL;
          end else begin
            mem_we = 1'b1;
            fill_d = fill_q + POS_W'(8);
            if (byte_q == 8'd0) begin
              zrun_d = (zrun_q == 2'd2) ? zrun_q : zrun_q + 2'd1;
            end else begin
              zrun_d = '0;
            end
          end
        end
        OP_SKIP: begin
          if (arg_q > rem) begin
            fail_d = 1'b1;
          end else begin
            pos_d = pos_q + arg_q;
          end
        end
        OP_ALIGN: begin
          pos_d = aligned;
        end
        default: begin
        end
      endcase
    end
  end

  // Result values; a failed item reports zero.
  always_comb begin
    res_rval_d = '0;
    res_sval_d = '0;
    if (!fail_q) begin
      case (op_q)
        OP_READ_BITS: res_rval_d = acc_q;
        OP_READ_UE:   res_rval_d = {32'd0, acc_q[31:0] - 32'd1};
        OP_READ_SE:   res_sval_d = acc_q[0] ? (32'd0 - half) : half;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = cmd_i.commit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fill_q      <= '0;
      zrun_q      <= '0;
      strip_q     <= 1'b1;
      out_valid_q <= 1'b0;
      fail_q      <= 1'b0;
      status_q    <= ST_OK;
      dropped_q   <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      zrun_q      <= zrun_d;
      out_valid_q <= out_valid_d;
      fail_q      <= fail_d;
      status_q    <= status_d;
      dropped_q   <= dropped_d;
      if (cfg_we_i) begin
        strip_q <= cfg_wdata_i;
      end
    end
  end

  // Byte store with a registered read port that follows the read position.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[fill_q[ADDR_W+2:3]] <= byte_q;
    end
    rdata_q <= mem[pos_q[ADDR_W+2:3]];
  end

  // For codes the accumulator starts at the marker bit, so it ends up
  // holding the code value plus one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_i;
      arg_q  <= bit_count_arg_i;
      byte_q <= byte_in_i;
    end
    if (cmd_i.init_read) begin
      acc_q    <= '0;
      cnt_q    <= arg_q[CNT_W-1:0];
      prefix_q <= 1'b0;
    end
    if (cmd_i.init_ue) begin
      acc_q    <= 64'd1;
      lz_q     <= '0;
      prefix_q <= 1'b1;
    end
    if (cmd_i.step) begin
      if (prefix_q) begin
        if (bit_val) begin
          prefix_q <= 1'b0;
          cnt_q    <= {{(CNT_W-LZ_W){1'b0}}, lz_q};
        end else begin
          lz_q <= lz_q + LZ_W'(1);
        end
      end else begin
        acc_q <= {acc_q[62:0], bit_val};
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
    if (cmd_i.commit) begin
      res_status_q  <= fail_q ? ST_FAIL : status_q;
      res_dropped_q <= dropped_q;
      res_pos_q     <= pos_q;
      res_rem_q     <= rem;
      res_rval_q    <= res_rval_d;
      res_sval_q    <= res_sval_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_status_q;
  assign read_value_o    = res_rval_q;
  assign signed_value_o  = res_sval_q;
  assign byte_dropped_o  = res_dropped_q;
  assign position_out_o  = res_pos_q;
  assign remaining_out_o = res_rem_q;

  `EGB_ASSERT_SAME(a_pos_within_fill, clk_i, rst_ni, 1'b1, pos_q <= fill_q)
  `EGB_ASSERT_SAME(a_fill_byte_multiple, clk_i, rst_ni, 1'b1, fill_q[2:0] == 3'd0)
  `EGB_ASSERT_SAME(a_commit_when_free, clk_i, rst_ni, cmd_i.commit, !out_valid_q || !out_stall_i)
  `EGB_ASSERT_NEXT(a_append_grows_fill, clk_i, rst_ni, mem_we, fill_q == $past(fill_q) + POS_W'(8))

endmodule

[src/exp_golomb_bitstream_reader.sv]
// ---------------------------------------------------------------------------
// Exp-Golomb bitstream reader
// MSB-first bit reader over a byte store with Exp-Golomb code decoding.
// ---------------------------------------------------------------------------
// Usage: items enter on in_valid_i/in_stall_o with op_i, bit_count_arg_i and
// byte_in_i; every accepted item yields exactly one result transfer on
// out_valid_o/out_stall_i. cfg_we_i writes the emulation-byte strip enable
// from cfg_wdata_i; the user must write it only while the block is idle,
// which the block itself does not enforce. Items are handled one at a time.
// Clear, append, skip, align and any item that fails its length check pass
// from decode straight to the result. A read of n bits takes n bit steps,
// with a fetch before each stored byte it touches. An Exp-Golomb code of z
// leading zeros walks 2z+1 bits the same way. The fetch comes from the
// registered read port of the byte store.
// The result sits in an output register; a new item is taken while it waits,
// and a stalled result holds until taken, with the next item then waiting
// in its final cycle. Reset empties the buffer, zeroes the read position and
// sets stripping on; the byte store needs no clearing pass.
// ---------------------------------------------------------------------------
module exp_golomb_bitstream_reader
  import egb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [15:0]        bit_count_arg_i,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [63:0]        read_value_o,
  output logic signed [31:0] signed_value_o,
  output logic               byte_dropped_o,
  output logic [15:0]        position_out_o,
  output logic [15:0]        remaining_out_o
);

  egb_cmd_t  cmd;
  egb_stat_t stat;

  egb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  egb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (op_i),
    .bit_count_arg_i (bit_count_arg_i),
    .byte_in_i       (byte_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .signed_value_o  (signed_value_o),
    .byte_dropped_o  (byte_dropped_o),
    .position_out_o  (position_out_o),
    .remaining_out_o (remaining_out_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule
